// ----- rtl/ffd_pkg.sv -----
package ffd_pkg;

    // Field widths of the sample path.
    localparam int ACCEL_W = 16;
    localparam int MAG_W   = 15;
    localparam int CFG_W   = 16;

    // Magnitudes are averaged over blocks of this many samples.
    localparam int AVERAGE_WINDOW = 101;
    localparam int COUNT_W        = $clog2(AVERAGE_WINDOW);
    localparam int TOTAL_W        = 22;

    // Shift-add unit: three lanes of 16 x 16 bits, sum up to 33 bits.
    localparam int MAC_LANES = 3;
    localparam int MAC_W     = 16;
    localparam int MAC_CNT_W = $clog2(MAC_W);
    localparam int SUM_W     = 33;

    // Bit-serial divider: 24-bit dividend, 15-bit divisor.
    localparam int DIV_W     = 24;
    localparam int DSR_W     = 15;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCORE_FLOOR   = 2'd0;
    localparam logic [1:0] CFG_SCORE_CEILING = 2'd1;
    localparam logic [1:0] CFG_SCORE_GAIN    = 2'd2;

    localparam logic [7:0]  FLOOR_RESET   = 8'd20;
    localparam logic [7:0]  CEILING_RESET = 8'd75;
    localparam logic [15:0] GAIN_RESET    = 16'd1300;

    typedef struct packed {
        logic              mode;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } in_t;

    typedef struct packed {
        logic [14:0] magnitude;
        logic [7:0]  fall_score;
        logic [7:0]  weightless_run;
        logic [14:0] peak_impact;
        logic        falling;
    } out_t;

    // Status of a multi-cycle arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ----- rtl/free_fall_detector.sv -----
// Free-fall detector for three-axis accelerometer samples. Each input beat
// with mode 0 carries one sample; the block forms the floor square root of
// x*x + y*y + z*z (saturated to 32767), keeps a block average of the
// magnitudes over AVERAGE_WINDOW samples, and treats a sample below half
// of the latest average as weightless. A weightless sample raises the
// duration count and adds score_gain * duration / magnitude to the fall
// score, which is then clamped to [score_floor, score_ceiling]. A beat with
// mode 1 lowers a nonzero fall score by one. Every input beat yields
// exactly one output beat. One beat is processed at a time: a sample passes
// through the bit-serial sum of squares and the two-bits-per-cycle square
// root; the sample that closes an averaging block then runs the division
// that forms the new average, and a weightless sample with nonzero magnitude
// runs the serial gain*duration product and the bit-serial division. A
// decrement beat goes straight to the output stage. The next beat is
// accepted as soon as the result is in the output register, even while that
// result still waits on a stalled output. Configuration writes are expected
// only while the block is idle.
module free_fall_detector (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  ffd_pkg::in_t              in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output ffd_pkg::out_t             out_data,
    input  logic                      cfg_write,
    input  logic [1:0]                cfg_index,
    input  logic [ffd_pkg::CFG_W-1:0] cfg_data
);
    import ffd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_ROOT = 3'd2;
    localparam logic [2:0] S_AVG  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam int RAD_W      = 2 * ((SUM_W + 1) / 2);
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int ROOT_W     = ROOT_STEPS;
    localparam int REM_W      = ROOT_W + 1;
    localparam int STEP_W     = $clog2(ROOT_STEPS);
    localparam logic [MAG_W-1:0]   MAG_MAX   = {MAG_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        logic [15:0] u;
        u = v;
        return v[15] ? (~u + 16'd1) : u;
    endfunction

    // Saturating add of the increment, then floor, then ceiling.
    function automatic logic [7:0] clamp_score(input logic [7:0] s,
                                               input logic [DIV_W-1:0] inc,
                                               input logic [7:0] fl,
                                               input logic [7:0] ce);
        logic [16:0] s17;
        logic [15:0] sum;
        s17 = {9'd0, s} + {1'b0, inc[15:0]};
        if (inc[DIV_W-1:16] != '0 || s17[16])
        begin
            sum = 16'hFFFF;
        end
        else
        begin
            sum = s17[15:0];
        end
        if (sum < {8'd0, fl})
        begin
            sum = {8'd0, fl};
        end
        if (sum > {8'd0, ce})
        begin
            sum = {8'd0, ce};
        end
        return sum[7:0];
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [MAG_W-1:0]    avg_reg, avg_next;
    logic [7:0]          dur_reg, dur_next;
    logic [7:0]          score_reg, score_next;
    logic [MAG_W-1:0]    peak_reg, peak_next;
    logic [7:0]          floor_reg, ceil_reg;
    logic [15:0]         gain_reg;
    logic                out_valid_reg, out_valid_next;
    out_t                out_reg;
    logic                out_load;

    logic                in_accept;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic                root_fits;
    logic [MAG_W-1:0]    mag_root;
    logic [TOTAL_W:0]    total_sum;
    logic [TOTAL_W-1:0]  total_sat;
    logic                weightless;
    logic [7:0]          dur_inc;

    logic                                mac_start;
    logic [MAC_LANES-1:0][MAC_W-1:0]     mac_a, mac_b;
    logic [SUM_W-1:0]                    mac_sum;
    unit_stat_t                          mac_stat;
    logic                                div_start;
    logic [DIV_W-1:0]                    div_dividend;
    logic [DSR_W-1:0]                    div_divisor;
    logic [DIV_W-1:0]                    div_quot;
    unit_stat_t                          div_stat;

    ffd_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .mcand  (mac_a),
        .mplier (mac_b),
        .sum    (mac_sum),
        .stat   (mac_stat)
    );

    ffd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    // One step of the digit-by-digit square root: two radicand bits per cycle.
    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial     = {1'b0, root_reg, 2'b01};
        root_fits = (rem_sh >= trial);
    end

    always_comb
    begin
        if (root_fits)
        begin
            rem_next = REM_W'(rem_sh - trial);
        end
        else
        begin
            rem_next = rem_sh[REM_W-1:0];
        end
        root_next = {root_reg[ROOT_W-2:0], root_fits};
        mag_root  = (root_next > ROOT_W'(MAG_MAX)) ? MAG_MAX : root_next[MAG_W-1:0];
    end

    always_comb
    begin
        total_sum  = {1'b0, total_reg} + (TOTAL_W + 1)'(mag_root);
        total_sat  = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
        weightless = (mag_reg < (avg_reg >> 1));
        dur_inc    = (dur_reg != 8'hFF) ? (dur_reg + 8'd1) : dur_reg;
    end

    // Operand selection for the shared units.
    always_comb
    begin
        mac_a = '0;
        mac_b = '0;
        if (state_reg == S_IDLE)
        begin
            mac_a[0] = abs16(in_data.accel_x);
            mac_a[1] = abs16(in_data.accel_y);
            mac_a[2] = abs16(in_data.accel_z);
            mac_b    = mac_a;
        end
        else
        begin
            mac_a[0] = gain_reg;
            mac_b[0] = {8'd0, dur_inc};
        end

        if (state_reg == S_ROOT)
        begin
            div_dividend = DIV_W'(total_sat);
            div_divisor  = DSR_W'(AVERAGE_WINDOW);
        end
        else
        begin
            div_dividend = mac_sum[DIV_W-1:0];
            div_divisor  = mag_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rad_next   = rad_reg;
        step_next  = step_reg;
        mag_next   = mag_reg;
        total_next = total_reg;
        count_next = count_reg;
        avg_next   = avg_reg;
        dur_next   = dur_reg;
        score_next = score_reg;
        peak_next  = peak_reg;
        mac_start  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.mode)
                    begin
                        // Decrement beat: only the score moves; the magnitude reads zero.
                        mag_next = '0;
                        if (score_reg != 8'd0)
                        begin
                            score_next = score_reg - 8'd1;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mac_start  = 1'b1;
                        state_next = S_SQ;
                    end
                end
            end
            S_SQ:
            begin
                if (mac_stat.done)
                begin
                    rad_next   = RAD_W'(mac_sum);
                    step_next  = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    mag_next = mag_root;
                    if (count_reg == COUNT_W'(AVERAGE_WINDOW - 1))
                    begin
                        // Block closes: the new average is needed before the
                        // threshold compare of this same sample.
                        total_next = '0;
                        count_next = '0;
                        div_start  = 1'b1;
                        state_next = S_AVG;
                    end
                    else
                    begin
                        total_next = total_sat;
                        count_next = count_reg + 1'b1;
                        state_next = S_CMP;
                    end
                end
            end
            S_AVG:
            begin
                if (div_stat.done)
                begin
                    if (div_quot > DIV_W'(MAG_MAX))
                    begin
                        avg_next = MAG_MAX;
                    end
                    else
                    begin
                        avg_next = div_quot[MAG_W-1:0];
                    end
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (weightless)
                begin
                    dur_next = dur_inc;
                    if (mag_reg == '0)
                    begin
                        // The quotient saturates, so the score lands on
                        // the ceiling.
                        score_next = clamp_score(score_reg, {DIV_W{1'b1}},
                                                 floor_reg, ceil_reg);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mac_start  = 1'b1;
                        state_next = S_MUL;
                    end
                end
                else if (score_reg != 8'd0)
                begin
                    if (peak_reg < mag_reg)
                    begin
                        peak_next = mag_reg;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    dur_next   = '0;
                    peak_next  = '0;
                    state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                if (mac_stat.done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    score_next = clamp_score(score_reg, div_quot, floor_reg, ceil_reg);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            avg_reg       <= '0;
            dur_reg       <= '0;
            score_reg     <= '0;
            peak_reg      <= '0;
            floor_reg     <= FLOOR_RESET;
            ceil_reg      <= CEILING_RESET;
            gain_reg      <= GAIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            avg_reg       <= avg_next;
            dur_reg       <= dur_next;
            score_reg     <= score_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SCORE_FLOOR:   floor_reg <= cfg_data[7:0];
                    CFG_SCORE_CEILING: ceil_reg  <= cfg_data[7:0];
                    CFG_SCORE_GAIN:    gain_reg  <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    // Square root working registers and the result payload.
    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        mag_reg <= mag_next;
        if (state_reg == S_SQ)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (state_reg == S_ROOT)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        if (out_load)
        begin
            out_reg.magnitude      <= mag_reg;
            out_reg.fall_score     <= score_reg;
            out_reg.weightless_run <= dur_reg;
            out_reg.peak_impact    <= peak_reg;
            out_reg.falling        <= (score_reg != 8'd0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The two arithmetic units are never running when no beat is in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!mac_stat.busy && !div_stat.busy))
        else $error("arithmetic unit busy while idle");

    // The averaging counter never reaches the window length.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < COUNT_W'(AVERAGE_WINDOW - 1) || count_reg == COUNT_W'(AVERAGE_WINDOW - 1))
        else $error("sample count out of range");

    // A weightless update leaves the score at or below the ceiling.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_stat.done) |=> (score_reg <= ceil_reg))
        else $error("score above ceiling after weightless sample");

    // The falling flag always agrees with the score it is sent with.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.falling == (out_reg.fall_score != 8'd0)))
        else $error("falling flag disagrees with fall score");

    // A result is loaded only when the output register is free or draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten");

endmodule

// ----- rtl/ffd_mac.sv -----
module ffd_mac (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic [ffd_pkg::MAC_LANES-1:0][ffd_pkg::MAC_W-1:0] mcand,
    input  logic [ffd_pkg::MAC_LANES-1:0][ffd_pkg::MAC_W-1:0] mplier,
    output logic [ffd_pkg::SUM_W-1:0]                         sum,
    output ffd_pkg::unit_stat_t                               stat
);
    import ffd_pkg::*;

    // Sum of three products, one multiplier bit per lane per cycle.
    logic [MAC_LANES-1:0][2*MAC_W-1:0] mcand_reg;
    logic [MAC_LANES-1:0][MAC_W-1:0]   mplier_reg;
    logic [SUM_W-1:0]                  acc_reg, acc_next;
    logic [MAC_CNT_W-1:0]              cnt_reg;
    logic                              busy_reg, done_reg;

    always_comb
    begin
        acc_next = acc_reg;
        for (int l = 0; l < MAC_LANES; l++)
        begin
            if (mplier_reg[l][0])
            begin
                acc_next = acc_next + SUM_W'(mcand_reg[l]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MAC_CNT_W'(MAC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            for (int l = 0; l < MAC_LANES; l++)
            begin
                mcand_reg[l]  <= {{MAC_W{1'b0}}, mcand[l]};
                mplier_reg[l] <= mplier[l];
            end
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            for (int l = 0; l < MAC_LANES; l++)
            begin
                mcand_reg[l]  <= {mcand_reg[l][2*MAC_W-2:0], 1'b0};
                mplier_reg[l] <= {1'b0, mplier_reg[l][MAC_W-1:1]};
            end
        end
    end

    assign sum       = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- rtl/ffd_div.sv -----
module ffd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ffd_pkg::DIV_W-1:0]   dividend,
    input  logic [ffd_pkg::DSR_W-1:0]   divisor,
    output logic [ffd_pkg::DIV_W-1:0]   quotient,
    output ffd_pkg::unit_stat_t         stat
);
    import ffd_pkg::*;

    // Restoring division, one quotient bit per cycle. The dividend register
    // shifts out at the top while quotient bits shift in at the bottom.
    logic [DIV_W-1:0]     quo_reg;
    logic [DSR_W-1:0]     rem_reg;
    logic [DSR_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;
    logic [DSR_W:0]       rem_sh;
    logic [DSR_W:0]       rem_diff;
    logic                 q_bit;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
        rem_diff = rem_sh - {1'b0, dsr_reg};
        q_bit    = (rem_sh >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], q_bit};
            rem_reg <= q_bit ? rem_diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- verif/free_fall_detector_tb.sv -----
`timescale 1ns / 100ps

module free_fall_detector_tb;

    import ffd_pkg::*;

    // Hard ceiling on the run. Even if every beat cost the slowest correct
    // beat plus the longest sender gap and the longest receiver stall, the
    // whole run would stay well below this, even taken several times over.
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned TOTAL_MAX   = 4194303;
    localparam int unsigned MAG_MAX     = 32767;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_BEATS = 250;
    localparam int unsigned SHOWN_FAULTS = 10;

    // One row of the directed table. Rows whose result is obvious carry it
    // typed in; the others are checked against the predictor.
    typedef struct packed {
        in_t  beat;
        logic known;
        out_t res;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    in_t               in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    out_t              out_data;
    logic              cfg_write = 1'b0;
    logic [1:0]        cfg_index = CFG_SCORE_FLOOR;
    logic [CFG_W-1:0]  cfg_data = '0;

    // Predictor copy of the detector state and its registers.
    int unsigned mag_total;
    int unsigned window_fill;
    int unsigned level_avg;
    int unsigned weightless_len;
    int unsigned fall_lvl;
    int unsigned impact_max;
    int unsigned cfg_floor;
    int unsigned cfg_ceiling;
    int unsigned cfg_gain;

    // Results predicted for accepted beats, oldest first.
    out_t        pending_reports [$];
    out_t        head;
    int unsigned fault_count = 0;
    int unsigned report_count = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_hold = 0;

    // When set, neither side inserts gaps or stalls.
    bit steady = 1'b0;

    // After reset the block average is zero, so no sample can be weightless
    // and every result carries a zero score, duration and peak. The table
    // walks the axis extremes (every bit of each axis toggles), saturation of
    // the root, and decrement beats with junk on the ignored axes.
    row_t directed_rows [15] = '{
        '{'{1'b0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{15'd0, 8'd0, 8'd0, 15'd0, 1'b0}},
        '{'{1'b0, 16'sd3, 16'sd4, 16'sd0}, 1'b1, '{15'd5, 8'd0, 8'd0, 15'd0, 1'b0}},
        '{'{1'b0, -16'sd3, 16'sd0, -16'sd4}, 1'b1, '{15'd5, 8'd0, 8'd0, 15'd0, 1'b0}},
        '{'{1'b0, 16'sd1, 16'sd1, 16'sd1}, 1'b0, '0},
        '{'{1'b0, 16'sd2, 16'sd2, 16'sd2}, 1'b0, '0},
        '{'{1'b0, 16'sh7FFF, 16'sd0, 16'sd0}, 1'b1, '{15'd32767, 8'd0, 8'd0, 15'd0, 1'b0}},
        '{'{1'b0, 16'sh8000, 16'sd0, 16'sd0}, 1'b1, '{15'd32767, 8'd0, 8'd0, 15'd0, 1'b0}},
        '{'{1'b0, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b1,
          '{15'd32767, 8'd0, 8'd0, 15'd0, 1'b0}},
        '{'{1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b1,
          '{15'd32767, 8'd0, 8'd0, 15'd0, 1'b0}},
        '{'{1'b0, 16'sd0, -16'sd1, 16'sd0}, 1'b1, '{15'd1, 8'd0, 8'd0, 15'd0, 1'b0}},
        '{'{1'b0, 16'sd18918, 16'sd18918, 16'sd18918}, 1'b0, '0},
        '{'{1'b1, 16'sh7FFF, 16'sh8000, 16'shFFFF}, 1'b1, '{15'd0, 8'd0, 8'd0, 15'd0, 1'b0}},
        '{'{1'b1, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{15'd0, 8'd0, 8'd0, 15'd0, 1'b0}},
        '{'{1'b0, 16'sd100, 16'sd0, 16'sd0}, 1'b1, '{15'd100, 8'd0, 8'd0, 15'd0, 1'b0}},
        '{'{1'b0, 16'sd0, 16'sd0, -16'sd12000}, 1'b1,
          '{15'd12000, 8'd0, 8'd0, 15'd0, 1'b0}}
    };

    free_fall_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Floor square root by the classic digit-pair method, saturated to the
    // 15-bit magnitude range.
    function automatic logic [14:0] floor_root(logic [32:0] n);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem = n;
        root = 0;
        probe = 64'd1 << 34;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return (root > MAG_MAX) ? 15'h7FFF : root[14:0];
    endfunction

    // Advances the predicted detector by one accepted beat and returns the
    // result that beat must produce.
    function automatic out_t advance_detector(in_t b);
        out_t            r;
        longint          ax;
        longint          ay;
        longint          az;
        longint unsigned sq;
        longint unsigned inc;
        longint unsigned sum;
        logic [14:0]     mag;
        mag = '0;
        if (b.mode)
        begin
            // A decrement touches nothing but a nonzero score.
            if (fall_lvl != 0)
                fall_lvl = fall_lvl - 1;
        end
        else
        begin
            ax = $signed(b.accel_x);
            ay = $signed(b.accel_y);
            az = $signed(b.accel_z);
            sq = ax * ax + ay * ay + az * az;
            mag = floor_root(sq[32:0]);

            // Block averaging: the average changes only when a block closes.
            mag_total = mag_total + mag;
            if (mag_total > TOTAL_MAX)
                mag_total = TOTAL_MAX;
            window_fill = window_fill + 1;
            if (window_fill >= AVERAGE_WINDOW)
            begin
                level_avg = mag_total / window_fill;
                if (level_avg > MAG_MAX)
                    level_avg = MAG_MAX;
                mag_total = 0;
                window_fill = 0;
            end

            if (mag < level_avg / 2)
            begin
                // Weightless: a zero magnitude makes the increment saturate,
                // the sum saturates at 16 bits, then floor and ceiling apply
                // in that order so the ceiling wins when they cross.
                if (weightless_len < 255)
                    weightless_len = weightless_len + 1;
                if (mag == 0)
                    inc = 64'hFFFF_FFFF;
                else
                    inc = (longint'(cfg_gain) * weightless_len) / mag;
                sum = fall_lvl + inc;
                if (sum > 64'hFFFF)
                    sum = 64'hFFFF;
                if (sum < cfg_floor)
                    sum = cfg_floor;
                if (sum > cfg_ceiling)
                    sum = cfg_ceiling;
                fall_lvl = 32'(sum);
            end
            else if (fall_lvl != 0)
            begin
                if (impact_max < mag)
                    impact_max = mag;
            end
            else
            begin
                weightless_len = 0;
                impact_max = 0;
            end
        end
        r.magnitude = mag;
        r.fall_score = fall_lvl[7:0];
        r.weightless_run = weightless_len[7:0];
        r.peak_impact = impact_max[14:0];
        r.falling = (fall_lvl != 0);
        return r;
    endfunction

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned pick;
        if (steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 88)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Uniform value in [-span, span], as a 16-bit two's complement axis.
    function automatic logic [15:0] jitter(int unsigned span);
        return 16'($urandom_range(0, 2 * span)) - 16'(span);
    endfunction

    // Offers one beat, waits for acceptance, and records what it must yield.
    // The valid line is lowered only when a gap follows, so back-to-back
    // beats never see it dropped and raised within one time step.
    task automatic send_beat(in_t b, logic known, out_t typed_res);
        out_t        guess;
        int unsigned gap;
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        guess = advance_detector(b);
        pending_reports.push_back(known ? typed_res : guess);
        gap = idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lets every outstanding beat come back so the block is idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes all three score registers back to back on consecutive edges,
    // keeping the write enable high across them.
    task automatic set_limits(int unsigned lo, int unsigned hi, int unsigned gain);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SCORE_FLOOR;
        cfg_data <= CFG_W'(lo);
        @(posedge clk);
        cfg_index <= CFG_SCORE_CEILING;
        cfg_data <= CFG_W'(hi);
        @(posedge clk);
        cfg_index <= CFG_SCORE_GAIN;
        cfg_data <= CFG_W'(gain);
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_floor = lo;
        cfg_ceiling = hi;
        cfg_gain = gain;
    endtask

    // Random traffic shaped as short scenes of a falling device: resting
    // near one g, weightless stretches (some with a zero vector), impacts,
    // runs of decrements, mostly short but now and then long, and
    // some raw noise. The very first scene rests long enough to close an
    // averaging block, so later weightless samples fall below threshold.
    task automatic run_phase(int unsigned quota, bit warm_up);
        int unsigned done;
        int unsigned scene;
        int unsigned len;
        int unsigned span;
        in_t         b;
        done = 0;
        while (done < quota)
        begin
            scene = warm_up && done == 0 ? 0 : $urandom_range(0, 99);
            if (warm_up && done == 0)
                len = 110;
            else if (scene < 35)
                len = $urandom_range(5, 60);
            else if (scene < 60)
                len = $urandom_range(1, 12);
            else if (scene < 70)
                len = $urandom_range(1, 3);
            else if (scene < 85)
                len = ($urandom_range(0, 9) < 3) ? $urandom_range(40, 90)
                                                 : $urandom_range(1, 6);
            else
                len = $urandom_range(1, 10);
            repeat (len)
            begin
                b.mode = 1'b0;
                if (scene < 35)
                begin
                    b.accel_x = jitter(600);
                    b.accel_y = jitter(600);
                    b.accel_z = ($urandom_range(0, 1) ? 16'd16384 : 16'hC000) + jitter(1200);
                end
                else if (scene < 60)
                begin
                    span = $urandom_range(0, 1500);
                    if ($urandom_range(0, 9) < 3)
                        span = 0;
                    b.accel_x = jitter(span);
                    b.accel_y = jitter(span);
                    b.accel_z = jitter(span);
                end
                else if (scene < 70)
                begin
                    b.accel_x = ($urandom_range(0, 1) ? 16'($urandom_range(20000, 32767))
                                                      : 16'h8000 + 16'($urandom_range(0, 12767)));
                    b.accel_y = jitter(32767);
                    b.accel_z = jitter(32767);
                end
                else if (scene < 85)
                begin
                    b.mode = 1'b1;
                    b.accel_x = 16'($urandom);
                    b.accel_y = 16'($urandom);
                    b.accel_z = 16'($urandom);
                end
                else
                begin
                    b.mode = 1'($urandom_range(0, 1));
                    b.accel_x = 16'($urandom);
                    b.accel_y = 16'($urandom);
                    b.accel_z = 16'($urandom);
                end
                send_beat(b, 1'b0, '0);
                done = done + 1;
            end
        end
    endtask

    // Receiver side: mixes ready and stalled stretches of random
    // length; stall changes only at the clock edge.
    always @(posedge clk)
    begin
        if (stall_hold != 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else if (steady || $urandom_range(0, 2) != 0)
        begin
            out_stall <= 1'b0;
            stall_hold <= $urandom_range(0, 4);
        end
        else
        begin
            out_stall <= 1'b1;
            stall_hold <= idle_len();
        end
    end

    // Result checker: every beat that leaves the block is compared field
    // by field against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            report_count <= report_count + 1;
            if (pending_reports.size() == 0)
            begin
                if (fault_count < SHOWN_FAULTS)
                    $display("result %0d arrived with nothing outstanding", report_count);
                fault_count <= fault_count + 1;
            end
            else
            begin
                head = pending_reports.pop_front();
                if (out_data.magnitude !== head.magnitude
                    || out_data.fall_score !== head.fall_score
                    || out_data.weightless_run !== head.weightless_run
                    || out_data.peak_impact !== head.peak_impact
                    || out_data.falling !== head.falling)
                begin
                    if (fault_count < SHOWN_FAULTS)
                        $display({"result %0d mismatch: exp mag %0d score %0d run %0d",
                                  " peak %0d falling %0d, got mag %0d score %0d run %0d",
                                  " peak %0d falling %0d"},
                                 report_count, head.magnitude, head.fall_score,
                                 head.weightless_run, head.peak_impact, head.falling,
                                 out_data.magnitude, out_data.fall_score,
                                 out_data.weightless_run, out_data.peak_impact,
                                 out_data.falling);
                    fault_count <= fault_count + 1;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        mag_total = 0;
        window_fill = 0;
        level_avg = 0;
        weightless_len = 0;
        fall_lvl = 0;
        impact_max = 0;
        cfg_floor = FLOOR_RESET;
        cfg_ceiling = CEILING_RESET;
        cfg_gain = GAIN_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].known, directed_rows[i].res);
        drain();

        // Phase 0 runs on the reset limits. Later phases cover the widest
        // window with the largest gain (the score sum saturates), a floor
        // above the ceiling, a zero gain with a zero window, both limits at
        // the top, and one random setting. Phase 3 runs without any idling.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            steady = (ph == 3);
            case (ph)
                1: set_limits(0, 255, 65535);
                2: set_limits(255, 0, 1);
                3: set_limits(0, 0, 0);
                4: set_limits(255, 255, 65535);
                5: set_limits($urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 65535));
                default: ;
            endcase
            run_phase(PHASE_BEATS, ph == 0);
            drain();
        end

        // The drain above already waited out the last result; allow one
        // more full worst-case beat for anything spurious to show up.
        repeat (120) @(posedge clk);
        if (fault_count == 0 && pending_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
